>>> hw/rtl/cpp_pkg.sv
// shared types, constants and arithmetic helpers of the camera projection block
// no dependencies; used by every module of the block
package cpp_pkg;

  localparam int COORD_FRAC_BITS = 12;
  localparam int CORDIC_STAGES   = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

  // fov clamp limits in degrees Q8.8 and the degrees-to-turns divisor
  localparam logic [15:0] FOV_MIN = 16'd10240;
  localparam logic [15:0] FOV_MAX = 16'd40960;
  localparam logic [30:0] FOV_DIV = 31'd720;

  // per-item datapath widths
  localparam int DELTA_BITS    = 33;
  localparam int TERM_BITS     = 35;
  localparam int SUM_BITS      = 37;
  localparam int MAG_BITS      = 36;
  localparam int REM_BITS      = MAG_BITS;
  localparam int DIVIDEND_BITS = MAG_BITS + 24;
  localparam int DIV_BITS      = DIVIDEND_BITS - COORD_FRAC_BITS;
  localparam int FOCAL_BITS    = 34;
  localparam int LO_BITS       = 24;
  localparam int PROD_BITS     = DIV_BITS + FOCAL_BITS;
  localparam int SAT_BIT       = 80 - COORD_FRAC_BITS;
  localparam int OFF_BITS      = 41;
  localparam int SCR_BITS      = 42;
  localparam int NUM_MQ        = 14;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               visible;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_CAMERA_X, CFG_CAMERA_Y, CFG_CAMERA_Z, CFG_PITCH,
    CFG_YAW, CFG_ROLL, CFG_FOV, CFG_SCREEN
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SET_START, SET_FOV_DIV, SET_ROT_LOAD, SET_ROT_ITER, SET_FOC_LOAD,
    SET_FOC_DIV, SET_MUL, SET_AXES, SET_READY
  } set_state_e;

  // camera geometry handed from the setup unit to the item pipeline
  typedef struct packed {
    logic [2:0][31:0]        cam;
    logic [8:0][31:0]        axis;
    logic [FOCAL_BITS-1:0]   focal;
    logic [15:0]             scr_w;
    logic [15:0]             scr_h;
  } geom_t;

  typedef struct packed {
    logic [REM_BITS-1:0] r;
    logic [DIV_BITS-1:0] n;
  } div_state_t;

  typedef struct packed {
    div_state_t          x;
    div_state_t          y;
    logic [REM_BITS-1:0] den;
    logic                neg_x;
    logic                neg_y;
    logic                ok;
  } div_item_t;

  // arctangent of 2^-i in 32-bit turns
  function automatic logic [29:0] atan_turn(logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp to [-1, 1] in Q2.30
  function automatic logic signed [31:0] clamp1(logic signed [33:0] v);
    logic signed [33:0] c;
    if (v > ONE_Q30) c = ONE_Q30;
    else if (v < -ONE_Q30) c = -ONE_Q30;
    else c = v;
    return c[31:0];
  endfunction

  // Q2.30 product, round half up
  function automatic logic signed [31:0] mq(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    p = p >>> 30;
    return p[31:0];
  endfunction

  // one restoring division step
  function automatic div_state_t div_step(div_state_t s, logic [REM_BITS-1:0] d);
    logic [REM_BITS:0] t;
    logic [REM_BITS:0] diff;
    logic              ge;
    div_state_t        o;
    t    = {s.r, s.n[DIV_BITS-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    o.r  = ge ? diff[REM_BITS-1:0] : t[REM_BITS-1:0];
    o.n  = {s.n[DIV_BITS-2:0], ge};
    return o;
  endfunction

endpackage

>>> hw/rtl/cpp_setup.sv
// configuration registers and the sequencer that derives camera axes and focal length
// depends on cpp_pkg; one shared cordic, divider and multiplier, stepped over cycles
module cpp_setup import cpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output geom_t       geom_o,
  output logic        ready_o
);

  logic signed [31:0] cam_q [3];
  logic [15:0] pitch_q, yaw_q, roll_q, fov_q;
  logic [31:0] screen_q;

  set_state_e state_q, state_d;
  logic [5:0] cnt_q;
  logic [1:0] ang_q;

  logic [63:0] div_n_q;
  logic [30:0] div_r_q, div_d_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic flip_q;
  logic signed [31:0] sin_q [4];
  logic signed [31:0] cos_q [4];
  logic signed [31:0] prod_q [NUM_MQ];
  logic signed [31:0] axis_q [9];
  logic [FOCAL_BITS-1:0] focal_q;

  // control outputs
  logic last_div, last_rot, last_mul;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
      pitch_q  <= '0;
      yaw_q    <= '0;
      roll_q   <= '0;
      fov_q    <= 16'd23040;
      screen_q <= 32'd70780800;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAMERA_X: cam_q[0] <= cfg_data_i;
        CFG_CAMERA_Y: cam_q[1] <= cfg_data_i;
        CFG_CAMERA_Z: cam_q[2] <= cfg_data_i;
        CFG_PITCH:    pitch_q  <= cfg_data_i[15:0];
        CFG_YAW:      yaw_q    <= cfg_data_i[15:0];
        CFG_ROLL:     roll_q   <= cfg_data_i[15:0];
        CFG_FOV:      fov_q    <= cfg_data_i[15:0];
        CFG_SCREEN:   screen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = SET_START;
    end else begin
      case (state_q)
        SET_START:    state_d = SET_FOV_DIV;
        SET_FOV_DIV:  if (last_div) state_d = SET_ROT_LOAD;
        SET_ROT_LOAD: state_d = SET_ROT_ITER;
        SET_ROT_ITER: if (last_rot) state_d = (ang_q == 2'd3) ? SET_FOC_LOAD : SET_ROT_LOAD;
        SET_FOC_LOAD: state_d = (sin_q[3] > 32'sd0) ? SET_FOC_DIV : SET_MUL;
        SET_FOC_DIV:  if (last_div) state_d = SET_MUL;
        SET_MUL:      if (last_mul) state_d = SET_AXES;
        SET_AXES:     state_d = SET_READY;
        SET_READY:    state_d = SET_READY;
        default:      state_d = SET_START;
      endcase
    end
  end

  // outputs of the sequencer
  always_comb begin
    ready_o  = (state_q == SET_READY);
    last_div = (cnt_q == 6'd63);
    last_rot = (cnt_q == 6'(CORDIC_STAGES - 1));
    last_mul = (cnt_q == 6'(NUM_MQ - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SET_START;
      cnt_q   <= '0;
      ang_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d == state_q) ? cnt_q + 6'd1 : '0;
      if (state_d == SET_START) ang_q <= '0;
      else if (state_q == SET_ROT_ITER && last_rot) ang_q <= ang_q + 2'd1;
    end
  end

  // shared divider step
  logic [31:0] dv_t;
  logic        dv_ge;
  logic [31:0] dv_diff;
  logic [30:0] dv_r;
  logic [63:0] dv_n;
  always_comb begin
    dv_t    = {div_r_q, div_n_q[63]};
    dv_diff = dv_t - {1'b0, div_d_q};
    dv_ge   = (dv_t >= {1'b0, div_d_q});
    dv_r    = dv_ge ? dv_diff[30:0] : dv_t[30:0];
    dv_n    = {div_n_q[62:0], dv_ge};
  end

  // fov clamp
  logic [15:0] fov_c;
  always_comb begin
    if (fov_q < FOV_MIN) fov_c = FOV_MIN;
    else if (fov_q > FOV_MAX) fov_c = FOV_MAX;
    else fov_c = fov_q;
  end

  // cordic angle select and fold to [-90, 90] degrees
  logic [31:0] turn;
  logic signed [33:0] z0, zf;
  logic flip0;
  always_comb begin
    case (ang_q)
      2'd0:    turn = {pitch_q, 16'd0};
      2'd1:    turn = {yaw_q, 16'd0};
      2'd2:    turn = {roll_q, 16'd0};
      default: turn = div_n_q[31:0];
    endcase
    z0    = 34'(signed'(turn));
    flip0 = 1'b0;
    zf    = z0;
    if (z0 > ONE_Q30) begin
      zf    = z0 - 34'sd2147483648;
      flip0 = 1'b1;
    end else if (z0 < -ONE_Q30) begin
      zf    = z0 + 34'sd2147483648;
      flip0 = 1'b1;
    end
  end

  // cordic rotation step
  logic signed [33:0] nx, ny, nz, atn;
  always_comb begin
    atn = 34'(atan_turn(cnt_q[4:0]));
    if (z_q >= 34'sd0) begin
      nx = x_q - (y_q >>> cnt_q[4:0]);
      ny = y_q + (x_q >>> cnt_q[4:0]);
      nz = z_q - atn;
    end else begin
      nx = x_q + (y_q >>> cnt_q[4:0]);
      ny = y_q - (x_q >>> cnt_q[4:0]);
      nz = z_q + atn;
    end
  end

  // operand select of the shared q2.30 multiplier
  logic signed [31:0] op_a, op_b;
  always_comb begin
    case (cnt_q[3:0])
      4'd0:    begin op_a = cos_q[0]; op_b = cos_q[1]; end
      4'd1:    begin op_a = cos_q[0]; op_b = sin_q[1]; end
      4'd2:    begin op_a = sin_q[2]; op_b = sin_q[0]; end
      4'd3:    begin op_a = cos_q[2]; op_b = sin_q[1]; end
      4'd4:    begin op_a = cos_q[2]; op_b = cos_q[1]; end
      4'd5:    begin op_a = sin_q[2]; op_b = cos_q[0]; end
      4'd6:    begin op_a = cos_q[2]; op_b = sin_q[0]; end
      4'd7:    begin op_a = sin_q[2]; op_b = sin_q[1]; end
      4'd8:    begin op_a = cos_q[1]; op_b = sin_q[2]; end
      4'd9:    begin op_a = cos_q[2]; op_b = cos_q[0]; end
      4'd10:   begin op_a = prod_q[2]; op_b = cos_q[1]; end
      4'd11:   begin op_a = prod_q[2]; op_b = sin_q[1]; end
      4'd12:   begin op_a = prod_q[6]; op_b = cos_q[1]; end
      4'd13:   begin op_a = prod_q[6]; op_b = sin_q[1]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  logic signed [31:0] ch_pos;
  assign ch_pos = (cos_q[3] < 32'sd0) ? 32'sd0 : cos_q[3];

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      SET_START: begin
        div_n_q <= {24'd0, fov_c, 24'd0};
        div_r_q <= '0;
        div_d_q <= FOV_DIV;
      end
      SET_FOV_DIV, SET_FOC_DIV: begin
        div_n_q <= dv_n;
        div_r_q <= dv_r;
        if (state_q == SET_FOC_DIV && last_div) focal_q <= dv_n[FOCAL_BITS-1:0];
      end
      SET_ROT_LOAD: begin
        x_q    <= GAIN_Q30;
        y_q    <= '0;
        z_q    <= zf;
        flip_q <= flip0;
      end
      SET_ROT_ITER: begin
        x_q <= nx;
        y_q <= ny;
        z_q <= nz;
        if (last_rot) begin
          sin_q[ang_q] <= clamp1(flip_q ? -ny : ny);
          cos_q[ang_q] <= clamp1(flip_q ? -nx : nx);
        end
      end
      SET_FOC_LOAD: begin
        div_n_q <= {2'd0, 47'(screen_q[15:0] * ch_pos[30:0]), 15'd0};
        div_r_q <= '0;
        div_d_q <= sin_q[3][30:0];
        focal_q <= '0;
      end
      SET_MUL: prod_q[cnt_q[3:0]] <= mq(op_a, op_b);
      SET_AXES: begin
        axis_q[0] <= prod_q[0];
        axis_q[1] <= prod_q[1];
        axis_q[2] <= sin_q[0];
        axis_q[3] <= clamp1(34'(prod_q[10]) - 34'(prod_q[3]));
        axis_q[4] <= clamp1(34'(prod_q[11]) + 34'(prod_q[4]));
        axis_q[5] <= clamp1(-34'(prod_q[5]));
        axis_q[6] <= clamp1(-(34'(prod_q[12]) + 34'(prod_q[7])));
        axis_q[7] <= clamp1(34'(prod_q[8]) - 34'(prod_q[13]));
        axis_q[8] <= prod_q[9];
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) geom_o.cam[i] = cam_q[i];
    for (int i = 0; i < 9; i++) geom_o.axis[i] = axis_q[i];
    geom_o.focal = focal_q;
    geom_o.scr_w = screen_q[15:0];
    geom_o.scr_h = screen_q[31:16];
  end

endmodule

>>> hw/rtl/cpp_rotate.sv
// camera-space transform: offset from the camera and rotation by the camera axes
// depends on cpp_pkg; three register stages
module cpp_rotate import cpp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  in_item_t                   item_i,
  input  geom_t                      geom_i,
  output logic                       valid_o,
  output logic signed [SUM_BITS-1:0] tx_o,
  output logic signed [SUM_BITS-1:0] ty_o,
  output logic signed [SUM_BITS-1:0] tz_o
);

  logic [2:0] v_q;
  logic signed [DELTA_BITS-1:0] d_q [3];
  logic signed [TERM_BITS-1:0]  term_q [9];
  logic signed [SUM_BITS-1:0]   tx_q, ty_q, tz_q;

  // valid bits travel with the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[1:0], valid_i};
  end

  // stage 1: offset from the camera
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= DELTA_BITS'(item_i.world_x) - DELTA_BITS'(signed'(geom_i.cam[0]));
      d_q[1] <= DELTA_BITS'(item_i.world_y) - DELTA_BITS'(signed'(geom_i.cam[1]));
      d_q[2] <= DELTA_BITS'(item_i.world_z) - DELTA_BITS'(signed'(geom_i.cam[2]));
    end
  end

  // stage 2: nine rounded products, axis k uses delta k mod 3
  logic signed [65:0] pr [9];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pr[k] = d_q[k % 3] * signed'(geom_i.axis[k]);
      pr[k] = (pr[k] + 66'sd536870912) >>> 30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) term_q[k] <= pr[k][TERM_BITS-1:0];
    end
  end

  // stage 3: exact sums
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tz_q <= SUM_BITS'(term_q[0]) + SUM_BITS'(term_q[1]) + SUM_BITS'(term_q[2]);
      tx_q <= SUM_BITS'(term_q[3]) + SUM_BITS'(term_q[4]) + SUM_BITS'(term_q[5]);
      ty_q <= SUM_BITS'(term_q[6]) + SUM_BITS'(term_q[7]) + SUM_BITS'(term_q[8]);
    end
  end

  assign valid_o = v_q[2];
  assign tx_o    = tx_q;
  assign ty_o    = ty_q;
  assign tz_o    = tz_q;

endmodule

>>> hw/rtl/cpp_divide.sv
// pipelined restoring divider: |tx| and |ty| scaled by 2^24 over depth, one bit a stage
// depends on cpp_pkg; DIV_BITS register stages
module cpp_divide import cpp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [SUM_BITS-1:0] tx_i,
  input  logic signed [SUM_BITS-1:0] ty_i,
  input  logic signed [SUM_BITS-1:0] tz_i,
  output logic                       valid_o,
  output div_item_t                  item_o
);

  localparam logic signed [SUM_BITS-1:0] DEPTH_MIN = SUM_BITS'(1) <<< COORD_FRAC_BITS;

  div_item_t stage_q [DIV_BITS];
  logic [DIV_BITS-1:0] v_q;
  div_item_t first;

  // magnitudes and the initial partial remainders
  logic signed [SUM_BITS-1:0] ax, ay;
  logic [DIVIDEND_BITS-1:0] nx, ny;
  always_comb begin
    ax = tx_i[SUM_BITS-1] ? -tx_i : tx_i;
    ay = ty_i[SUM_BITS-1] ? -ty_i : ty_i;
    nx = {ax[MAG_BITS-1:0], 24'd0};
    ny = {ay[MAG_BITS-1:0], 24'd0};
    first.x.r   = REM_BITS'(nx[DIVIDEND_BITS-1:DIV_BITS]);
    first.x.n   = nx[DIV_BITS-1:0];
    first.y.r   = REM_BITS'(ny[DIVIDEND_BITS-1:DIV_BITS]);
    first.y.n   = ny[DIV_BITS-1:0];
    first.den   = tz_i[REM_BITS-1:0];
    first.neg_x = tx_i[SUM_BITS-1];
    first.neg_y = ty_i[SUM_BITS-1];
    first.ok    = (tz_i >= DEPTH_MIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[DIV_BITS-2:0], valid_i};
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    div_item_t src;
    div_item_t nxt;
    if (k == 0) begin : g_first
      assign src = first;
    end else begin : g_next
      assign src = stage_q[k-1];
    end
    // one quotient bit for each coordinate
    always_comb begin
      nxt   = src;
      nxt.x = div_step(src.x, src.den);
      nxt.y = div_step(src.y, src.den);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= nxt;
      end
    end
  end

  assign valid_o = v_q[DIV_BITS-1];
  assign item_o  = stage_q[DIV_BITS-1];

endmodule

>>> hw/rtl/cpp_scale.sv
// focal scaling, saturation, screen centering and the output register
// depends on cpp_pkg; three register stages, the last one is the output item
module cpp_scale import cpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_item_t item_i,
  input  geom_t     geom_i,
  output logic      valid_o,
  output out_item_t item_o
);

  localparam int HI_BITS = DIV_BITS - LO_BITS;

  logic [2:0] v_q;
  logic [LO_BITS+FOCAL_BITS-1:0] xl_q, yl_q;
  logic [HI_BITS+FOCAL_BITS-1:0] xh_q, yh_q;
  logic neg_x_a_q, neg_y_a_q, ok_a_q;
  logic signed [OFF_BITS-1:0] ox_q, oy_q;
  logic ok_b_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[1:0], valid_i};
  end

  // stage a: partial products of ratio and focal length
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xl_q      <= item_i.x.n[LO_BITS-1:0] * geom_i.focal;
      xh_q      <= item_i.x.n[DIV_BITS-1:LO_BITS] * geom_i.focal;
      yl_q      <= item_i.y.n[LO_BITS-1:0] * geom_i.focal;
      yh_q      <= item_i.y.n[DIV_BITS-1:LO_BITS] * geom_i.focal;
      neg_x_a_q <= item_i.neg_x;
      neg_y_a_q <= item_i.neg_y;
      ok_a_q    <= item_i.ok;
    end
  end

  // stage b: combine, saturate, apply sign
  logic [PROD_BITS-1:0] px, py;
  logic sat_x, sat_y;
  logic [39:0] rx, ry;
  always_comb begin
    px    = PROD_BITS'(xl_q) + {xh_q, LO_BITS'(0)};
    py    = PROD_BITS'(yl_q) + {yh_q, LO_BITS'(0)};
    sat_x = |px[PROD_BITS-1:SAT_BIT];
    sat_y = |py[PROD_BITS-1:SAT_BIT];
    rx    = px[SAT_BIT-1:SAT_BIT-40];
    ry    = py[SAT_BIT-1:SAT_BIT-40];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox_q   <= neg_x_a_q ? -OFF_BITS'(rx) : OFF_BITS'(rx);
      oy_q   <= neg_y_a_q ? -OFF_BITS'(ry) : OFF_BITS'(ry);
      ok_b_q <= ok_a_q && !sat_x && !sat_y;
    end
  end

  // stage c: center on the screen and range check
  logic signed [SCR_BITS-1:0] sx, sy;
  logic fit;
  always_comb begin
    sx  = signed'(SCR_BITS'({geom_i.scr_w, (COORD_FRAC_BITS-1)'(0)})) + SCR_BITS'(ox_q);
    sy  = signed'(SCR_BITS'({geom_i.scr_h, (COORD_FRAC_BITS-1)'(0)})) - SCR_BITS'(oy_q);
    fit = ((&sx[SCR_BITS-1:31]) || !(|sx[SCR_BITS-1:31]))
       && ((&sy[SCR_BITS-1:31]) || !(|sy[SCR_BITS-1:31]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.visible  <= ok_b_q && fit;
      out_q.screen_x <= (ok_b_q && fit) ? sx[31:0] : '0;
      out_q.screen_y <= (ok_b_q && fit) ? sy[31:0] : '0;
    end
  end

  assign valid_o = v_q[2];
  assign item_o  = out_q;

endmodule

>>> hw/rtl/camera_perspective_projection.sv
// Camera perspective projection, world point to screen point.
// Input channel: in_valid_i / in_stall_o with one world point per item (Q20.12).
// Output channel: out_valid_o / out_stall_i with screen x, y (Q20.12) and visible.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (camera x, y, z,
// pitch, yaw, roll, field of view, screen size) with no wait state.
// Throughput: one item per cycle unless the output stalls or the setup runs. Items pass
// through cpp_rotate, the restoring divider (one quotient bit per stage) and cpp_scale.
// After reset and after every configuration write the setup sequencer rebuilds
// the camera axes and focal length with one shared cordic, divider and
// multiplier, while in_stall_o stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o rises; bubbles are filled while the output register is empty.
// Depends on cpp_pkg, cpp_setup, cpp_rotate, cpp_divide and cpp_scale.
module camera_perspective_projection import cpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  geom_t geom;
  logic  ready;
  logic  en;
  logic  rot_valid, div_valid;
  logic signed [SUM_BITS-1:0] tx, ty, tz;
  div_item_t div_item;

  // pipeline advances unless a finished item is held
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en || !ready;

  cpp_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom),
    .ready_o    (ready)
  );

  cpp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && !in_stall_o),
    .item_i  (in_item_i),
    .geom_i  (geom),
    .valid_o (rot_valid),
    .tx_o    (tx),
    .ty_o    (ty),
    .tz_o    (tz)
  );

  cpp_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rot_valid),
    .tx_i    (tx),
    .ty_i    (ty),
    .tz_i    (tz),
    .valid_o (div_valid),
    .item_o  (div_item)
  );

  cpp_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .item_i  (div_item),
    .geom_i  (geom),
    .valid_o (out_valid_o),
    .item_o  (out_item_o)
  );

  // an invisible point carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.visible |-> out_item_o.screen_x == 0 && out_item_o.screen_y == 0)
    else $error("invisible item with nonzero coordinates");

  // no item is taken while the setup is rebuilding
  assert property (@(posedge clk_i) disable iff (!rst_ni) !ready |-> in_stall_o)
    else $error("input taken during setup");

  // a configuration write restarts the setup
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_we_i |=> !ready)
    else $error("setup not restarted after configuration write");

endmodule

>>> dv/cpp_checker.sv
// checker for the camera projection block: watches the config port and both item channels,
// predicts each screen point and compares it with the block's output
// depends on cpp_pkg
module cpp_checker import cpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 64'sd1073741824;

  longint atan_tbl [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81};

  // shadow copy of the camera registers
  logic [31:0] cam_pos [3];
  logic [15:0] pitch_q, yaw_q, roll_q, fov_q;
  logic [31:0] screen_q;

  out_item_t expected_points[$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_points.size();

  function automatic longint clip_unit(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  // rotation-mode cordic over the half turn folded to +-90 degrees
  function automatic void turn_sincos(input logic [31:0] turn, output longint s,
                                      output longint c);
    longint z, x, y, nx, ny;
    bit     flip;
    z = longint'(turn);
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > ONE) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -ONE) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tbl[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tbl[i];
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = clip_unit(y);
    c = clip_unit(x);
  endfunction

  function automatic longint axis_dot(longint d0, longint d1, longint d2,
                                      longint a0, longint a1, longint a2);
    return ((d0 * clip_unit(a0) + 64'sd536870912) >>> 30)
         + ((d1 * clip_unit(a1) + 64'sd536870912) >>> 30)
         + ((d2 * clip_unit(a2) + 64'sd536870912) >>> 30);
  endfunction

  // |t| * focal / depth as a Q.F offset, 0 on saturation
  function automatic bit lateral_offset(input longint t, input longint depth,
                                        input longint unsigned focal, output longint off);
    longint unsigned mag, ratio;
    logic [127:0]    prod;
    mag   = (t < 0) ? longint'(-t) : longint'(t);
    ratio = (mag << 24) / longint'(depth);
    prod  = {64'd0, ratio} * {64'd0, focal};
    prod  = prod >> (40 - COORD_FRAC_BITS);
    if (prod >= (128'd1 << 40)) return 0;
    off = (t < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    return 1;
  endfunction

  function automatic out_item_t project_point(in_item_t p);
    longint sp, cp, sy, cy, sr, cr, sh, ch;
    longint d0, d1, d2, tx, ty, tz, ox, oy, sx, syv;
    longint unsigned w, h, fov, focal;
    bit ok;
    out_item_t r;
    w = screen_q[15:0];
    h = screen_q[31:16];
    ox = 0;
    oy = 0;
    focal = 0;
    d0 = longint'(p.world_x) - longint'($signed(cam_pos[0]));
    d1 = longint'(p.world_y) - longint'($signed(cam_pos[1]));
    d2 = longint'(p.world_z) - longint'($signed(cam_pos[2]));
    turn_sincos({pitch_q, 16'd0}, sp, cp);
    turn_sincos({yaw_q, 16'd0}, sy, cy);
    turn_sincos({roll_q, 16'd0}, sr, cr);
    tz = axis_dot(d0, d1, d2, qmul(cp, cy), qmul(cp, sy), sp);
    tx = axis_dot(d0, d1, d2, qmul(qmul(sr, sp), cy) - qmul(cr, sy),
                  qmul(qmul(sr, sp), sy) + qmul(cr, cy), -qmul(sr, cp));
    ty = axis_dot(d0, d1, d2, -(qmul(qmul(cr, sp), cy) + qmul(sr, sy)),
                  qmul(cy, sr) - qmul(qmul(cr, sp), sy), qmul(cr, cp));
    // focal length from the clamped half angle
    fov = fov_q;
    if (fov < FOV_MIN) fov = FOV_MIN;
    if (fov > FOV_MAX) fov = FOV_MAX;
    turn_sincos(32'((fov << 24) / 720), sh, ch);
    if (ch < 0) ch = 0;
    if (sh > 0) focal = ((w * longint'(ch)) << 15) / longint'(sh);
    ok = tz >= (64'sd1 << COORD_FRAC_BITS);
    if (ok) ok = lateral_offset(tx, tz, focal, ox) && lateral_offset(ty, tz, focal, oy);
    sx  = longint'(w << (COORD_FRAC_BITS - 1)) + ox;
    syv = longint'(h << (COORD_FRAC_BITS - 1)) - oy;
    if (ok && (sx > 64'sd2147483647 || sx < -64'sd2147483648 ||
               syv > 64'sd2147483647 || syv < -64'sd2147483648)) ok = 0;
    if (!ok) begin
      sx = 0;
      syv = 0;
    end
    r.screen_x = sx[31:0];
    r.screen_y = syv[31:0];
    r.visible  = ok;
    return r;
  endfunction

  // register shadow, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cam_pos[0] <= '0; cam_pos[1] <= '0; cam_pos[2] <= '0;
      pitch_q <= '0; yaw_q <= '0; roll_q <= '0;
      fov_q <= 16'd23040;
      screen_q <= 32'd70780800;
      expected_points.delete();
      fails <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_points.push_back(project_point(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected result item: x=%0d y=%0d visible=%0b",
            out_item_i.screen_x, out_item_i.screen_y, out_item_i.visible);
        end else begin
          want = expected_points.pop_front();
          if (want !== out_item_i) begin
            fails <= fails + 1;
            if (fails < 10) $display("mismatch: expected x=%0d y=%0d v=%0b, got x=%0d y=%0d v=%0b",
              want.screen_x, want.screen_y, want.visible,
              out_item_i.screen_x, out_item_i.screen_y, out_item_i.visible);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CAMERA_X: cam_pos[0] <= cfg_data_i;
          CFG_CAMERA_Y: cam_pos[1] <= cfg_data_i;
          CFG_CAMERA_Z: cam_pos[2] <= cfg_data_i;
          CFG_PITCH:    pitch_q <= cfg_data_i[15:0];
          CFG_YAW:      yaw_q <= cfg_data_i[15:0];
          CFG_ROLL:     roll_q <= cfg_data_i[15:0];
          CFG_FOV:      fov_q <= cfg_data_i[15:0];
          CFG_SCREEN:   screen_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> dv/tb_top.sv
// top of the camera projection testbench: clock, reset, config phases and point stimulus
// depends on cpp_pkg, cpp_checker and the camera_perspective_projection block
module tb_top;
  import cpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_item;
  int          fail_count, pending;
  int          cycles = 0;
  bit          quiet = 0;
  logic [31:0] cam_base [3];

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  camera_perspective_projection dut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item)
  );

  cpp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("camera_perspective_projection regression: fail");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk_i) out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 19);

  // hold the item until accepted, then maybe leave a gap
  task automatic send_point(in_item_t p);
    in_valid <= 1;
    in_item  <= p;
    do @(posedge clk_i); while (in_stall);
    if (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we   <= 1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near(logic [31:0] base);
    int span;
    span = $urandom_range(8, 28);
    return base + $signed({1'b0, 31'($urandom_range(0, 2 ** span))}) - (32'd1 << (span - 1));
  endfunction

  function automatic in_item_t random_point();
    in_item_t p;
    if ($urandom_range(99) < 80) begin
      p.world_x = near(cam_base[0]);
      p.world_y = near(cam_base[1]);
      p.world_z = near(cam_base[2]);
    end else begin
      p.world_x = $urandom;
      p.world_y = $urandom;
      p.world_z = $urandom;
    end
    return p;
  endfunction

  initial begin
    logic [31:0] pitch, yaw, roll, fov, scr;
    cam_base = '{default: '0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // directed points at the reset camera, looking down +x
    send_point('{32'sd40960, 32'sd0, 32'sd0});
    send_point('{32'sd0, 32'sd0, 32'sd0});
    send_point('{32'sd4096, 32'sd0, 32'sd0});
    send_point('{32'sd4095, 32'sd0, 32'sd0});
    send_point('{32'sd4096, 32'sd4096, -32'sd4096});
    send_point('{32'sd4096, 32'h7fffffff, 32'sd0});
    send_point('{32'sd4096, 32'sd0, 32'h80000000});
    send_point('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    send_point('{32'h80000000, 32'h80000000, 32'h80000000});
    send_point('{32'h7fffffff, 32'h80000000, 32'h7fffffff});
    send_point('{-32'sd40960, 32'sd4096, 32'sd4096});
    send_point('{32'sd409600, -32'sd409600, 32'sd409600});
    send_point('{32'sd4096, 32'sd40960000, 32'sd0});

    // config phases (the first keeps the reset config), each followed by random points
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      quiet = (ph == 4);
      if (ph > 0) begin
        case (ph)
          1: begin cam_base = '{default: '0}; pitch = 0; yaw = 0; roll = 0;
                   fov = 0; scr = {16'd480, 16'd640}; end
          2: begin cam_base = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
                   pitch = 16'hffff; yaw = 16'hffff; roll = 16'hffff;
                   fov = 16'hffff; scr = 32'hffffffff; end
          3: begin cam_base = '{default: '0}; pitch = 16'h4000; yaw = 16'hc000;
                   roll = 16'h8000; fov = 16'd23040; scr = {16'd1080, 16'd0}; end
          default: begin
            foreach (cam_base[k]) cam_base[k] = $urandom_range(0, 1) ? $urandom
                                                 : near(32'd0);
            pitch = $urandom_range(0, 65535); yaw = $urandom_range(0, 65535);
            roll = $urandom_range(0, 65535); fov = $urandom_range(0, 65535);
            scr = $urandom;
            if (ph == 8) scr = {16'd1, 16'd1};
          end
        endcase
        write_reg(CFG_CAMERA_X, cam_base[0]);
        write_reg(CFG_CAMERA_Y, cam_base[1]);
        write_reg(CFG_CAMERA_Z, cam_base[2]);
        write_reg(CFG_PITCH, pitch);
        write_reg(CFG_YAW, yaw);
        write_reg(CFG_ROLL, roll);
        write_reg(CFG_FOV, fov);
        write_reg(CFG_SCREEN, scr);
        cfg_we <= 0;
      end
      repeat (172) send_point(random_point());
    end

    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) $display("camera_perspective_projection regression: pass");
    else $display("camera_perspective_projection regression: fail");
    $finish;
  end

endmodule
